@@ src/two_axis_easing_interpolator_top_assert.svh @@
// Assertion macros for the checker file of the easing interpolator.
// No dependencies.
`ifndef TWO_AXIS_EASING_INTERPOLATOR_TOP_ASSERT_SVH
`define TWO_AXIS_EASING_INTERPOLATOR_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TEIP_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define TEIP_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/teip_pkg.sv @@
// Shared types and constants of the two-axis easing interpolator.
// No dependencies.
package teip_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DURATION   = 3'd0;
  localparam logic [2:0] CFG_START_X    = 3'd1;
  localparam logic [2:0] CFG_START_Y    = 3'd2;
  localparam logic [2:0] CFG_END_X      = 3'd3;
  localparam logic [2:0] CFG_END_Y      = 3'd4;
  localparam logic [2:0] CFG_CURVE_MODE = 3'd5;

  // Curve codes.
  localparam logic [2:0] CURVE_CIRC     = 3'd0;
  localparam logic [2:0] CURVE_SINE     = 3'd1;
  localparam logic [2:0] CURVE_CUBIC    = 3'd2;
  localparam logic [2:0] CURVE_QUINTIC  = 3'd3;
  localparam logic [2:0] CURVE_PINGPONG = 3'd4;
  localparam logic [2:0] CURVE_LINEAR   = 3'd5;

  localparam logic [16:0] Q16_ONE     = 17'h10000;
  localparam logic [16:0] Q16_HALF    = 17'h08000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // Rounded-up reciprocals for the constant divides of the sine series.
  // Each is exact for dividends below 2^30: 2^36/42, 2^35/20 and 2^33/6.
  localparam logic [30:0] RECIP_42 = 31'd1636178018;
  localparam logic [30:0] RECIP_20 = 31'd1717986919;
  localparam logic [30:0] RECIP_6  = 31'd1431655766;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [33:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  // Request to the square root unit.
  typedef struct packed {
    logic        start;
    logic [32:0] value;
  } sqrt_req_t;

endpackage

@@ src/teip_mul.sv @@
// Shared registered multiplier of the easing interpolator.
// No package dependencies.
module teip_mul (
  input  logic        clk,
  input  logic [33:0] a,
  input  logic [33:0] b,
  output logic [67:0] prod_r
);

  // One product per cycle, registered.
  always_ff @(posedge clk) begin
    prod_r <= {34'd0, a} * {34'd0, b};
  end

endmodule

@@ src/teip_div.sv @@
// Restoring divider, one quotient bit per cycle, 34-bit dividend by 16-bit divisor.
// Depends on teip_pkg.
module teip_div (
  input  logic               clk,
  input  logic               rst_n,
  input  teip_pkg::div_req_t req,
  output logic [33:0]        quot,
  output logic               done
);

  logic [15:0] rem_r, rem_nxt;
  logic [33:0] quo_r, quo_nxt;
  logic [15:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [16:0] trial;
  logic        take;

  // Trial subtraction of one step.
  always_comb begin
    trial   = {rem_r, quo_r[33]};
    take    = trial >= {1'b0, dvs_r};
    rem_nxt = take ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
    quo_nxt = {quo_r[32:0], take};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd33;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath of the iteration.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= 16'd0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quot = quo_r;
  assign done = done_r;

endmodule

@@ src/teip_sqrt.sv @@
// Bit-pair integer square root of a 33-bit value, one result bit per cycle.
// Depends on teip_pkg.
module teip_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  teip_pkg::sqrt_req_t req,
  output logic [16:0]         root,
  output logic                done
);

  logic [32:0] v_r;
  logic [33:0] r_r, bit_r;
  logic        busy_r, done_r;
  logic [33:0] t;
  logic        take;

  assign t    = r_r + bit_r;
  assign take = {1'b0, v_r} >= t;

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath of the iteration.
  always_ff @(posedge clk) begin
    if (req.start) begin
      v_r   <= req.value;
      r_r   <= 34'd0;
      bit_r <= 34'h1_0000_0000;
    end else if (busy_r) begin
      if (take) begin
        v_r <= 33'(({1'b0, v_r}) - t);
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = r_r[16:0];
  assign done = done_r;

endmodule

@@ src/two_axis_easing_interpolator_top.sv @@
// Top level of the two-axis easing interpolator: sequencer, registers, output stage.
// Depends on teip_pkg, teip_mul, teip_div and teip_sqrt.

// Each tick transaction is worked on alone by a sequencer around one shared
// multiplier, a one-bit-per-cycle divider for the progress and a square root
// unit. Each item runs the progress divide and the ease step; linear then goes
// straight to the two position multiplies, while ping-pong, cubic, quintic,
// sine, whose Taylor series divides by constants through reciprocal multiplies,
// and circular, which waits on the 17-step root, add their own steps first.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next tick is taken, and the sequencer holds
// its last step until that register is free.
module two_axis_easing_interpolator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_tick_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic [16:0] out_progress_fraction,
  output logic        out_finished,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [22:0] {
    ST_IDLE = 23'd1 << 0,  ST_DIVP = 23'd1 << 1,  ST_EASE = 23'd1 << 2,
    ST_PP2  = 23'd1 << 3,  ST_PP3  = 23'd1 << 4,  ST_C2   = 23'd1 << 5,
    ST_C3   = 23'd1 << 6,  ST_Q2   = 23'd1 << 7,  ST_Q3   = 23'd1 << 8,
    ST_Q4   = 23'd1 << 9,  ST_CI2  = 23'd1 << 10, ST_CIW  = 23'd1 << 11,
    ST_SX2  = 23'd1 << 12, ST_SH0  = 23'd1 << 13, ST_SHW  = 23'd1 << 14,
    ST_SHD  = 23'd1 << 15, ST_SS   = 23'd1 << 16, ST_SSS  = 23'd1 << 17,
    ST_SSE  = 23'd1 << 18, ST_FINH = 23'd1 << 19, ST_PX   = 23'd1 << 20,
    ST_PY   = 23'd1 << 21, ST_PD   = 23'd1 << 22
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] dur_r, elapsed_r;
  logic signed [15:0] sx_r, sy_r, ex_r, ey_r;
  logic [2:0]  mode_r;
  logic [16:0] p_r, e_r, h_r;
  logic        fin_r;
  logic [30:0] x_r, c_r;
  logic [31:0] x2_r;
  logic [1:0]  k_r;
  logic signed [15:0] px_r;

  logic        out_valid_r;
  logic signed [15:0] out_x_r, out_y_r;
  logic [16:0] out_p_r;
  logic        out_f_r;

  logic [33:0] mul_a, mul_b;
  logic [67:0] prod;
  teip_pkg::div_req_t  dreq;
  teip_pkg::sqrt_req_t sreq;
  logic [33:0] quot;
  logic        div_done, sqrt_done;
  logic [16:0] root;

  teip_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod));
  teip_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .quot(quot), .done(div_done));
  teip_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sreq), .root(root), .done(sqrt_done));

  // Tick accumulation and clamping.
  logic [15:0] dur;
  logic [16:0] acc;
  logic        over;
  logic [15:0] acc_c;
  assign dur   = (dur_r == 16'd0) ? 16'd1 : dur_r;
  assign acc   = {1'b0, elapsed_r} + {1'b0, in_tick_time};
  assign over  = acc > {1'b0, dur};
  assign acc_c = over ? dur : acc[15:0];

  // Curve helpers derived from the progress.
  logic        low;
  logic [16:0] nl, u, pp, m0, m;
  logic [23:0] p100;
  logic [30:0] rq, cq;
  assign low  = p_r <= teip_pkg::Q16_HALF;
  assign nl   = teip_pkg::Q16_ONE - p_r;
  assign u    = low ? {p_r[15:0], 1'b0} : {nl[15:0], 1'b0};
  assign pp   = low ? p_r : nl;
  assign p100 = {p_r, 6'd0} + {1'b0, p_r, 5'd0} + {5'd0, p_r, 2'd0};
  assign m0   = p100[16:0];
  assign m    = (m0 > teip_pkg::Q16_ONE) ? 17'(18'h20000 - {1'b0, m0}) : m0;

  // Quotient of the current series divide, taken from the reciprocal product.
  assign rq = (k_r == 2'd0) ? prod[66:36] :
              (k_r == 2'd1) ? prod[65:35] : prod[63:33];
  assign cq = teip_pkg::ONE_Q30 - rq;

  // Axis spans and their magnitudes.
  logic signed [16:0] dx, dy;
  logic [16:0] adx, ady;
  assign dx  = 17'(ex_r) - 17'(sx_r);
  assign dy  = 17'(ey_r) - 17'(sy_r);
  assign adx = dx[16] ? 17'(-dx) : dx;
  assign ady = dy[16] ? 17'(-dy) : dy;

  // Rounded, saturated position from the span magnitude product.
  function automatic logic signed [15:0] place(input logic signed [15:0] from,
                                               input logic neg,
                                               input logic [33:0] mag);
    logic signed [35:0] v;
    logic signed [35:0] n;
    logic signed [19:0] d;
    logic signed [20:0] r;
    v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    n = v + 36'sd32768;
    d = 20'(n >>> 16);
    r = 21'(from) + 21'(d);
    if (r > 21'sd32767) r = 21'sd32767;
    if (r < -21'sd32768) r = -21'sd32768;
    return r[15:0];
  endfunction

  // Multiplier operand selection.
  always_comb begin
    mul_a = 34'd0;
    mul_b = 34'd0;
    unique case (state_r)
      ST_EASE: begin
        if (mode_r == teip_pkg::CURVE_PINGPONG) begin
          mul_a = 34'(m);
          mul_b = 34'(m);
        end else if (mode_r == teip_pkg::CURVE_SINE) begin
          mul_a = 34'(pp);
          mul_b = 34'(teip_pkg::HALF_PI_Q30);
        end else begin
          mul_a = 34'(u);
          mul_b = 34'(u);
        end
      end
      ST_PP2: begin
        mul_a = prod[33:0];
        mul_b = 34'(18'd196608 - {m, 1'b0});
      end
      ST_C2: begin
        mul_a = prod[33:0];
        mul_b = 34'(u);
      end
      ST_Q2: begin
        mul_a = 34'(prod[32:16]);
        mul_b = 34'(prod[32:16]);
      end
      ST_Q3: begin
        mul_a = 34'(prod[32:16]);
        mul_b = 34'(u);
      end
      ST_SX2: begin
        mul_a = 34'(prod[46:16]);
        mul_b = 34'(prod[46:16]);
      end
      ST_SH0: begin
        mul_a = 34'(prod[61:30]);
        mul_b = 34'(teip_pkg::RECIP_42);
      end
      ST_SHW: begin
        mul_a = 34'(x2_r);
        mul_b = 34'(cq);
      end
      ST_SHD: begin
        mul_a = 34'(prod[60:30]);
        mul_b = (k_r == 2'd0) ? 34'(teip_pkg::RECIP_20) : 34'(teip_pkg::RECIP_6);
      end
      ST_SS: begin
        mul_a = 34'(x_r);
        mul_b = 34'(c_r);
      end
      ST_SSS: begin
        mul_a = 34'(prod[60:30]);
        mul_b = 34'(prod[60:30]);
      end
      ST_PX: begin
        mul_a = 34'(adx);
        mul_b = 34'(e_r);
      end
      ST_PY, ST_PD: begin
        mul_a = 34'(ady);
        mul_b = 34'(e_r);
      end
      default: begin
        mul_a = 34'd0;
        mul_b = 34'd0;
      end
    endcase
  end

  // Divider and root requests.
  always_comb begin
    dreq = '0;
    sreq = '0;
    if (state_r == ST_IDLE && in_valid) begin
      dreq.start    = 1'b1;
      dreq.dividend = {2'b00, acc_c, 16'd0};
      dreq.divisor  = dur;
    end
    if (state_r == ST_CI2) begin
      sreq.start = 1'b1;
      sreq.value = 33'h1_0000_0000 - prod[32:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIVP;
      ST_DIVP: if (div_done) state_nxt = ST_EASE;
      ST_EASE: begin
        case (mode_r)
          teip_pkg::CURVE_CIRC:     state_nxt = ST_CI2;
          teip_pkg::CURVE_SINE:     state_nxt = ST_SX2;
          teip_pkg::CURVE_CUBIC:    state_nxt = ST_C2;
          teip_pkg::CURVE_QUINTIC:  state_nxt = ST_Q2;
          teip_pkg::CURVE_PINGPONG: state_nxt = ST_PP2;
          default:                  state_nxt = ST_PX;
        endcase
      end
      ST_PP2:  state_nxt = ST_PP3;
      ST_PP3:  state_nxt = ST_PX;
      ST_C2:   state_nxt = ST_C3;
      ST_C3:   state_nxt = ST_FINH;
      ST_Q2:   state_nxt = ST_Q3;
      ST_Q3:   state_nxt = ST_Q4;
      ST_Q4:   state_nxt = ST_FINH;
      ST_CI2:  state_nxt = ST_CIW;
      ST_CIW:  if (sqrt_done) state_nxt = ST_FINH;
      ST_SX2:  state_nxt = ST_SH0;
      ST_SH0:  state_nxt = ST_SHW;
      ST_SHW:  state_nxt = (k_r == 2'd2) ? ST_SS : ST_SHD;
      ST_SHD:  state_nxt = ST_SHW;
      ST_SS:   state_nxt = ST_SSS;
      ST_SSS:  state_nxt = ST_SSE;
      ST_SSE:  state_nxt = ST_FINH;
      ST_FINH: state_nxt = ST_PX;
      ST_PX:   state_nxt = ST_PY;
      ST_PY:   state_nxt = ST_PD;
      ST_PD:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= 16'd0;
      out_valid_r <= 1'b0;
      dur_r       <= 16'd1;
      sx_r        <= 16'sd0;
      sy_r        <= 16'sd0;
      ex_r        <= 16'sd0;
      ey_r        <= 16'sd0;
      mode_r      <= teip_pkg::CURVE_LINEAR;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_valid) elapsed_r <= acc_c;
      if (state_r == ST_PD && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          teip_pkg::CFG_DURATION:   dur_r  <= cfg_data;
          teip_pkg::CFG_START_X:    sx_r   <= $signed(cfg_data);
          teip_pkg::CFG_START_Y:    sy_r   <= $signed(cfg_data);
          teip_pkg::CFG_END_X:      ex_r   <= $signed(cfg_data);
          teip_pkg::CFG_END_Y:      ey_r   <= $signed(cfg_data);
          teip_pkg::CFG_CURVE_MODE: mode_r <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) fin_r <= over;
    if (state_r == ST_DIVP && div_done) p_r <= quot[16:0];
    if (state_r == ST_EASE) begin
      e_r <= p_r;
      k_r <= 2'd0;
    end
    if (state_r == ST_PP3)  e_r  <= prod[48:32];
    if (state_r == ST_C3)   h_r  <= prod[49:33];
    if (state_r == ST_Q4)   h_r  <= prod[33:17];
    if (state_r == ST_CIW)  h_r  <= 17'((teip_pkg::Q16_ONE - root) >> 1);
    if (state_r == ST_SX2)  x_r  <= prod[46:16];
    if (state_r == ST_SH0)  x2_r <= prod[61:30];
    if (state_r == ST_SHW)  c_r  <= cq;
    if (state_r == ST_SHD)  k_r  <= k_r + 2'd1;
    if (state_r == ST_SH0)  k_r  <= 2'd0;
    if (state_r == ST_SSE)  h_r  <= 17'((prod[60:0] + 61'h800_0000_0000) >> 44);
    if (state_r == ST_FINH) e_r  <= low ? h_r : 17'(teip_pkg::Q16_ONE - h_r);
    if (state_r == ST_PY)   px_r <= place(sx_r, dx[16], prod[33:0]);
    if (state_r == ST_PD && (!out_valid_r || out_ready)) begin
      out_x_r <= px_r;
      out_y_r <= place(sy_r, dy[16], prod[33:0]);
      out_p_r <= p_r;
      out_f_r <= fin_r;
    end
  end

  assign in_ready              = state_r == ST_IDLE;
  assign out_valid             = out_valid_r;
  assign out_pos_x             = out_x_r;
  assign out_pos_y             = out_y_r;
  assign out_progress_fraction = out_p_r;
  assign out_finished          = out_f_r;

endmodule

@@ src/teip_checker.sv @@
// Port-level checker of the easing interpolator, bound to the top level.
// Depends on two_axis_easing_interpolator_top_assert.svh.
`include "two_axis_easing_interpolator_top_assert.svh"

module teip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_progress_fraction,
  input logic        out_finished,
  input logic [15:0] out_pos_x
);

  // A stalled result holds.
  `TEIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pos_x))
  // A finished result is at full progress.
  `TEIP_ASSERT_NOW(a_fin_full, clk, rst_n, out_valid && out_finished, out_progress_fraction == 17'h10000)
  // Progress never passes one.
  `TEIP_ASSERT_NOW(a_prog_max, clk, rst_n, out_valid, out_progress_fraction <= 17'h10000)
  // One transaction at a time: ready drops after an accepted tick.
  `TEIP_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind two_axis_easing_interpolator_top teip_checker u_teip_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_progress_fraction(out_progress_fraction), .out_finished(out_finished),
  .out_pos_x(out_pos_x)
);
